>>> rtl/dcc_pkg.sv
// ----------------------------------------------------------------------------
// dcc_pkg: shared types and constants for the day-count convention core
// Date record, pipeline control record, basis and calendar codes, and the
// cumulative month table used when a date is turned into a day ordinal.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int YW = 14;  // year width
  localparam int MW = 4;   // month width
  localparam int DW = 5;   // day width
  localparam int BW = 3;   // basis width
  localparam int CW = 23;  // day count width
  localparam int OW = 25;  // signed day ordinal width
  localparam int RW = 26;  // signed working width of a result before clamping

  typedef struct packed {
    logic [YW-1:0] y;
    logic [MW-1:0] m;
    logic [DW-1:0] d;
  } date_t;

  typedef struct packed {
    logic bad;     // basis code out of range
    logic actual;  // actual/actual day count
  } ctl_t;

  localparam logic [BW-1:0] BASIS_US = 3'd0;
  localparam logic [BW-1:0] BASIS_EU = 3'd4;

  localparam logic [MW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MW-1:0] MONTH_MAR = 4'd3;

  localparam logic [DW-1:0] DAY_28 = 5'd28;
  localparam logic [DW-1:0] DAY_29 = 5'd29;
  localparam logic [DW-1:0] DAY_31 = 5'd31;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every x below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  localparam logic signed [RW-1:0] DC_MIN = RW'(-1024);
  localparam logic signed [RW-1:0] DC_MAX = RW'(4194303);

  // Days in the months that precede month m; month 0 sits before January
  function automatic logic signed [9:0] days_before_month(input logic [MW-1:0] m,
                                                          input logic leap);
    logic signed [9:0] base;
    case (m)
      4'd0:    base = -10'sd30;
      4'd1:    base = 10'sd0;
      4'd2:    base = 10'sd31;
      4'd3:    base = 10'sd59;
      4'd4:    base = 10'sd90;
      4'd5:    base = 10'sd120;
      4'd6:    base = 10'sd151;
      4'd7:    base = 10'sd181;
      4'd8:    base = 10'sd212;
      4'd9:    base = 10'sd243;
      4'd10:   base = 10'sd273;
      4'd11:   base = 10'sd304;
      4'd12:   base = 10'sd334;
      4'd13:   base = 10'sd365;
      4'd14:   base = 10'sd395;
      4'd15:   base = 10'sd425;
      default: base = 10'sd0;
    endcase
    if (leap && (m >= MONTH_MAR)) begin
      base = base + 10'sd1;
    end
    return base;
  endfunction

endpackage

>>> rtl/dcc_order.sv
// ----------------------------------------------------------------------------
// dcc_order: date ordering stage
// Compares the two dates as (year, month, day) and registers them earlier
// first.
// ----------------------------------------------------------------------------
module dcc_order import dcc_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  date_t first,
  input  date_t second,
  output date_t lo,
  output date_t hi
);

  logic swap;

  // the packed record compares year, then month, then day
  assign swap = first > second;

  // hold the ordered pair
  always_ff @(posedge clk) begin
    if (en) begin
      lo <= swap ? second : first;
      hi <= swap ? first : second;
    end
  end

endmodule

>>> rtl/dcc_ordinal.sv
// ----------------------------------------------------------------------------
// dcc_ordinal: three-stage day ordinal pipeline for one date
// Stage one takes the century quotients by reciprocal multiplication, stage
// two sums the year days and decides the leap year, stage three adds the
// month offset and the day.
// ----------------------------------------------------------------------------
module dcc_ordinal import dcc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  date_t                dt,
  output logic                 leap,
  output logic signed [OW-1:0] ord
);

  localparam int PW = YW + 14;  // product width

  // quotient stage
  logic [YW:0]   y99;
  logic [YW:0]   y399;
  logic [PW-1:0] p100;
  logic [PW-1:0] p400;
  logic [PW-1:0] py;
  date_t         dt_q;
  logic [7:0]    q100;
  logic [7:0]    q400;
  logic [7:0]    qy;

  // year-day stage
  logic [23:0]   yx;
  logic [23:0]   y365;
  logic [YW:0]   y3;
  logic [YW-2:0] y4;
  logic [23:0]   yd_next;
  logic [YW:0]   hundred;
  logic          leap_next;
  logic [23:0]   yd;
  logic [MW-1:0] m_y;
  logic [DW-1:0] d_y;

  // divide the shifted years by 100 and 400, and the year itself by 100
  assign y99  = {1'b0, dt.y} + (YW+1)'(99);
  assign y399 = {1'b0, dt.y} + (YW+1)'(399);
  assign p100 = PW'(y99) * PW'(RECIP_100);
  assign p400 = PW'(y399[YW:2]) * PW'(RECIP_100);
  assign py   = PW'(dt.y) * PW'(RECIP_100);

  always_ff @(posedge clk) begin
    if (en) begin
      dt_q <= dt;
      q100 <= p100[RECIP_SHIFT +: 8];
      q400 <= p400[RECIP_SHIFT +: 8];
      qy   <= py[RECIP_SHIFT +: 8];
    end
  end

  // sum the days of all earlier years and test for a leap year
  assign yx      = 24'(dt_q.y);
  assign y365    = (yx << 8) + (yx << 6) + (yx << 5) + (yx << 3) + (yx << 2) + yx;
  assign y3      = {1'b0, dt_q.y} + (YW+1)'(3);
  assign y4      = y3[YW:2];
  assign yd_next = y365 + 24'(y4) - 24'(q100) + 24'(q400);
  assign hundred = ((YW+1)'(qy) << 6) + ((YW+1)'(qy) << 5) + ((YW+1)'(qy) << 2);
  assign leap_next = (dt_q.y[1:0] == 2'b00)
                   && ((hundred != {1'b0, dt_q.y}) || (qy[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    if (en) begin
      yd   <= yd_next;
      leap <= leap_next;
      m_y  <= dt_q.m;
      d_y  <= dt_q.d;
    end
  end

  // add the month offset and the day
  always_ff @(posedge clk) begin
    if (en) begin
      ord <= $signed({1'b0, yd}) + OW'(days_before_month(m_y, leap)) + OW'(d_y);
    end
  end

endmodule

>>> rtl/dcc_thirty.sv
// ----------------------------------------------------------------------------
// dcc_thirty: three-stage 30/360 pipeline
// Forms the month and day differences with the day-31 adjustments, scales
// the months by 30, then applies the end-of-February correction once the
// leap flag of the earlier year is known.
// ----------------------------------------------------------------------------
module dcc_thirty import dcc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  date_t                lo,
  input  date_t                hi,
  input  logic [BW-1:0]        basis,
  input  logic                 rules,
  input  logic                 leap,
  output logic signed [RW-1:0] r360
);

  // difference stage
  logic                is_us;
  logic                is_eu;
  logic [YW-1:0]       dy;
  logic [17:0]         dy12;
  logic [18:0]         months_next;
  logic [6:0]          days_next;
  logic                end31;
  logic                eu_dec;
  logic                same_date;
  logic signed [18:0]  months;
  logic signed [6:0]   days;
  logic                f28;
  logic                f29;
  logic                fy;

  // scale stage
  logic signed [RW-1:0] mx;
  logic signed [RW-1:0] base;
  logic                 f28_s;
  logic                 f29_s;
  logic                 fy_s;
  logic [1:0]           corr;

  assign is_us     = basis == BASIS_US;
  assign is_eu     = basis == BASIS_EU;
  assign dy        = hi.y - lo.y;
  assign dy12      = (18'(dy) << 3) + (18'(dy) << 2);
  assign months_next = {1'b0, dy12} + 19'(hi.m) - 19'(lo.m);
  assign end31     = (lo.d == DAY_31) && (hi.d != DAY_31);
  assign eu_dec    = rules && is_eu && (hi.d == DAY_31) && (lo.d != DAY_31);
  assign same_date = lo == hi;
  assign days_next = 7'(hi.d) - 7'(lo.d)
                   + ((rules && (is_us || is_eu) && end31) ? 7'd1 : 7'd0)
                   - (eu_dec ? 7'd1 : 7'd0);

  always_ff @(posedge clk) begin
    if (en) begin
      months <= $signed(months_next);
      days   <= $signed(days_next);
      f28    <= is_us && rules && (lo.m == MONTH_FEB) && (lo.d == DAY_28) && !same_date;
      f29    <= is_us && rules && (lo.m == MONTH_FEB) && (lo.d == DAY_29) && !same_date;
      fy     <= is_us && !rules && (lo.m == MONTH_FEB) && (hi.m != MONTH_FEB)
                && (lo.y == hi.y);
    end
  end

  // scale months by 30
  assign mx = RW'(months);

  always_ff @(posedge clk) begin
    if (en) begin
      base  <= (mx <<< 5) - (mx <<< 1) + RW'(days);
      f28_s <= f28;
      f29_s <= f29;
      fy_s  <= fy;
    end
  end

  // end-of-February correction: two days in a common year, one in a leap year
  always_comb begin
    if ((f28_s || fy_s) && !leap) begin
      corr = 2'd2;
    end else if ((f29_s || fy_s) && leap) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r360 <= base - RW'(corr);
    end
  end

endmodule

>>> rtl/day_count_convention_core.sv
// ----------------------------------------------------------------------------
// day_count_convention_core: day count between two dates
// Orders the dates, runs the 30/360 and actual day-ordinal paths side by
// side and selects and clamps the result for the requested basis.
// ----------------------------------------------------------------------------
// The core takes one date pair per clock cycle while result_ready does not stall it,
// and presents its result from the fifth register in line: the ordering
// register loaded at the input transfer, three stages through the
// day-ordinal and 30/360 paths, and the output register that selects and
// clamps. The whole pipeline advances together; while a result waits for
// result_ready, item_ready stays low.
module day_count_convention_core import dcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic [YW-1:0]        first_year,
  input  logic [MW-1:0]        first_month,
  input  logic [DW-1:0]        first_day,
  input  logic [YW-1:0]        second_year,
  input  logic [MW-1:0]        second_month,
  input  logic [DW-1:0]        second_day,
  input  logic [BW-1:0]        basis,
  input  logic                 date_rules,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic signed [CW-1:0] day_count,
  output logic                 bad_basis
);

  logic                 advance;
  date_t                first;
  date_t                second;
  date_t                lo_date;
  date_t                hi_date;
  ctl_t                 ctl_in;
  ctl_t                 ctl1;
  ctl_t                 ctl2;
  ctl_t                 ctl3;
  ctl_t                 ctl4;
  logic                 v1;
  logic                 v2;
  logic                 v3;
  logic                 v4;
  logic [BW-1:0]        basis1;
  logic                 rules1;
  logic                 leap_lo;
  logic                 leap_hi;
  logic signed [OW-1:0] ord_lo;
  logic signed [OW-1:0] ord_hi;
  logic signed [RW-1:0] r360;
  logic signed [OW-1:0] diff;
  logic signed [RW-1:0] r_sel;
  logic signed [CW-1:0] r_sat;

  // advance the whole pipeline whenever the output register can move
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;

  assign first  = '{y: first_year,  m: first_month,  d: first_day};
  assign second = '{y: second_year, m: second_month, d: second_day};

  assign ctl_in.bad    = basis > BASIS_EU;
  assign ctl_in.actual = (basis != BASIS_US) && (basis < BASIS_EU);

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= item_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      result_valid <= v4;
    end
  end

  // carry the basis decode alongside the data
  always_ff @(posedge clk) begin
    if (advance) begin
      ctl1   <= ctl_in;
      ctl2   <= ctl1;
      ctl3   <= ctl2;
      ctl4   <= ctl3;
      basis1 <= basis;
      rules1 <= date_rules;
    end
  end

  dcc_order u_order (
    .clk    (clk),
    .en     (advance),
    .first  (first),
    .second (second),
    .lo     (lo_date),
    .hi     (hi_date)
  );

  dcc_ordinal u_ord_lo (
    .clk  (clk),
    .en   (advance),
    .dt   (lo_date),
    .leap (leap_lo),
    .ord  (ord_lo)
  );

  dcc_ordinal u_ord_hi (
    .clk  (clk),
    .en   (advance),
    .dt   (hi_date),
    .leap (leap_hi),
    .ord  (ord_hi)
  );

  dcc_thirty u_thirty (
    .clk   (clk),
    .en    (advance),
    .lo    (lo_date),
    .hi    (hi_date),
    .basis (basis1),
    .rules (rules1),
    .leap  (leap_lo),
    .r360  (r360)
  );

  // select the path and clamp to the output range
  assign diff  = ord_hi - ord_lo;
  assign r_sel = ctl4.actual ? RW'(diff) : r360;

  always_comb begin
    if (r_sel < DC_MIN) begin
      r_sat = DC_MIN[CW-1:0];
    end else if (r_sel > DC_MAX) begin
      r_sat = DC_MAX[CW-1:0];
    end else begin
      r_sat = r_sel[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      day_count <= ctl4.bad ? {CW{1'b1}} : r_sat;
      bad_basis <= ctl4.bad;
    end
  end

  // the ordering stage never leaves the later date first
  a_order: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (lo_date <= hi_date))
    else $error("ordered dates out of sequence");

  // a valid bit moves from the first stage to the second on every advance
  a_shift: assert property (@(posedge clk) disable iff (rst)
    advance |=> (v2 == $past(v1)))
    else $error("valid bit lost or repeated between stages");

  // an invalid basis always reports minus one
  a_bad: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_basis) |-> (day_count == {CW{1'b1}}))
    else $error("invalid basis with a day count other than minus one");

  // a stalled result holds, and so do the leap flags behind it
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(day_count)
      && $stable(bad_basis) && $stable(leap_lo) && $stable(leap_hi)))
    else $error("stalled result or leap flags changed");

endmodule
